/* src/mcsr_pkg.sv */
// shared widths, types, register codes and reset values of the circle span rasteriser
`timescale 1ns / 1ps
`default_nettype none

package mcsr_pkg;

    localparam int DISPLAY_WIDTH  = 320;
    localparam int DISPLAY_HEIGHT = 240;

    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int CTR_W   = 12;
    localparam int RAD_W   = 10;
    localparam int PAINT_W = 16;
    localparam int STEP_W  = 11;
    localparam int DEC_W   = 16;
    localparam int SUB_W   = 3;
    localparam int COORD_W = 14;
    localparam int CFG_W   = 9;

    localparam logic [COL_W-1:0] RIGHT_RST =
        (DISPLAY_WIDTH > 511) ? 9'd511 : 9'(DISPLAY_WIDTH);
    localparam logic [ROW_W-1:0] BOTTOM_RST =
        (DISPLAY_HEIGHT > 255) ? 8'd255 : 8'(DISPLAY_HEIGHT);

    localparam logic [SUB_W-1:0] SUB_LAST_OUTLINE = 3'd7;
    localparam logic [SUB_W-1:0] SUB_LAST_FILL    = 3'd3;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_BOTTOM = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } t_kind;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DEC_W-1:0]   t_dec;
    typedef logic signed [STEP_W-1:0]  t_step;

    typedef struct packed {
        logic                      kind;
        logic signed [CTR_W-1:0]   center_x;
        logic signed [CTR_W-1:0]   center_y;
        logic        [RAD_W-1:0]   radius;
        logic                      fill_mode;
        logic        [PAINT_W-1:0] paint;
    } t_in_word;

    typedef struct packed {
        logic               visible;
        logic [COL_W-1:0]   span_start;
        logic [COL_W-1:0]   span_end;
        logic [ROW_W-1:0]   row;
        logic [PAINT_W-1:0] span_paint;
        logic               done_res;
    } t_span_word;

endpackage

`default_nettype wire

/* src/mcsr_in_if.sv */
// input channel: circle start and step words
`timescale 1ns / 1ps
`default_nettype none

interface mcsr_in_if import mcsr_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [CTR_W-1:0]   center_x;
    logic signed [CTR_W-1:0]   center_y;
    logic        [RAD_W-1:0]   radius;
    logic                      fill_mode;
    logic        [PAINT_W-1:0] paint;

    modport source (
        output valid, kind, center_x, center_y, radius, fill_mode, paint,
        input  ready
    );

    modport sink (
        input  valid, kind, center_x, center_y, radius, fill_mode, paint,
        output ready
    );

endinterface

`default_nettype wire

/* src/mcsr_out_if.sv */
// output channel: clipped write spans
`timescale 1ns / 1ps
`default_nettype none

interface mcsr_out_if import mcsr_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               visible;
    logic [COL_W-1:0]   span_start;
    logic [COL_W-1:0]   span_end;
    logic [ROW_W-1:0]   row;
    logic [PAINT_W-1:0] span_paint;
    logic               done_res;

    modport source (
        output valid, visible, span_start, span_end, row, span_paint, done_res,
        input  ready
    );

    modport sink (
        input  valid, visible, span_start, span_end, row, span_paint, done_res,
        output ready
    );

endinterface

`default_nettype wire

/* src/midpoint_circle_span_rasterizer.sv */
// top level of the midpoint circle span rasteriser
//
//   channel   direction  word                          handshake
//   i_item    in         start or step word            valid / ready
//   o_span    out        clipped span, row, colour     valid / ready
//   i_cfg_*   in         scissor register write        write enable only
//
// one word per cycle while the result is not stalled: input register, one pass of
// adders and clip compares, result register; the walk state updates from its own registers
// a start word gives no span, a step word gives exactly one
// a synchronous reset clears control, walk state and scissors
// a stalled result holds the input register only once it is also full
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_span_rasterizer import mcsr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    mcsr_in_if.sink               i_item,
    mcsr_out_if.source            o_span
);

    logic [COL_W-1:0] r_left, r_right;
    logic [ROW_W-1:0] r_top, r_bottom;

    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_span_word r_out;

    logic                    r_busy;
    logic signed [CTR_W-1:0] r_org_x, r_org_y;
    t_step                   r_step_x, r_step_y;
    t_dec                    r_dec;
    logic [SUB_W-1:0]        r_sub;
    logic                    r_filled;
    logic [PAINT_W-1:0]      r_paint;

    logic       adv;
    logic       at_last;
    logic       dec_neg;
    t_dec       dx, dy, inc, n_dec;
    t_step      nx, ny;
    logic       walk_end;
    t_coord     cx, cy, x, y, u, v, px, py, a, b, lo, hi, cl, cr, ct, cb;
    logic       row_ok, vis;
    t_span_word n_out;

    // scissor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= RIGHT_RST;
            r_bottom <= BOTTOM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data[ROW_W-1:0];
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data[ROW_W-1:0];
            endcase
        end
    end

    assign adv          = r_in_valid && (!r_out_valid || o_span.ready);
    assign i_item.ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in.kind      <= i_item.kind;
            r_in.center_x  <= i_item.center_x;
            r_in.center_y  <= i_item.center_y;
            r_in.radius    <= i_item.radius;
            r_in.fill_mode <= i_item.fill_mode;
            r_in.paint     <= i_item.paint;
        end
    end

    // walk step
    always_comb begin
        at_last  = (r_sub == (r_filled ? SUB_LAST_FILL : SUB_LAST_OUTLINE));
        dec_neg  = r_dec[DEC_W-1];
        dx       = t_dec'(r_step_x);
        dy       = t_dec'(r_step_y);
        inc      = dec_neg ? ((dx <<< 2) + 16'sd6) : (((dx - dy) <<< 2) + 16'sd10);
        n_dec    = r_dec + inc;
        nx       = r_step_x + 11'sd1;
        ny       = dec_neg ? r_step_y : (r_step_y - 11'sd1);
        walk_end = at_last && (nx > ny);
    end

    // span geometry and clipping
    always_comb begin
        cx = t_coord'(r_org_x);
        cy = t_coord'(r_org_y);
        x  = t_coord'(r_step_x);
        y  = t_coord'(r_step_y);
        cl = t_coord'({1'b0, r_left});
        cr = t_coord'({1'b0, r_right});
        ct = t_coord'({1'b0, r_top});
        cb = t_coord'({1'b0, r_bottom});
        lo = '0;
        hi = '0;
        a  = '0;
        b  = '0;
        if (r_filled) begin
            u  = r_sub[1] ? y : x;
            v  = r_sub[1] ? x : y;
            py = r_sub[0] ? (cy + v) : (cy - v);
            px = '0;
            a  = cx - u;
            b  = cx + u + 14'sd1;
        end else begin
            u  = r_sub[2] ? y : x;
            v  = r_sub[2] ? x : y;
            px = r_sub[0] ? (cx - u) : (cx + u);
            py = r_sub[1] ? (cy - v) : (cy + v);
        end
        row_ok = (py >= ct) && (py < cb);
        if (r_filled) begin
            vis = row_ok && !((a < cl) && (b < cl)) && !((a >= cr) && (b >= cr));
            lo  = (a > b) ? b : a;
            hi  = (a > b) ? a : b;
            if (lo < cl) begin
                lo = cl;
            end
            if (hi > cr) begin
                hi = cr;
            end
            if (lo > hi) begin
                a  = lo;
                lo = hi;
                hi = a;
            end
            vis = vis && (lo != hi);
        end else begin
            vis = row_ok && (px >= cl) && (px < cr);
            lo  = px;
            hi  = px + 14'sd1;
        end
        n_out.visible    = vis;
        n_out.span_start = vis ? lo[COL_W-1:0] : '0;
        n_out.span_end   = vis ? hi[COL_W-1:0] : '0;
        n_out.row        = vis ? py[ROW_W-1:0] : '0;
        n_out.span_paint = vis ? r_paint : '0;
        n_out.done_res   = walk_end;
        if (!r_busy) begin
            n_out = '0;
            n_out.done_res = 1'b1;
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_step_x <= '0;
            r_step_y <= '0;
            r_dec    <= '0;
            r_sub    <= '0;
            r_filled <= 1'b0;
            r_paint  <= '0;
        end else if (adv) begin
            if (r_in.kind == KIND_START) begin
                r_busy   <= 1'b1;
                r_org_x  <= r_in.center_x;
                r_org_y  <= r_in.center_y;
                r_step_x <= '0;
                r_step_y <= t_step'({1'b0, r_in.radius});
                r_dec    <= 16'sd3 - t_dec'({r_in.radius, 1'b0});
                r_sub    <= '0;
                r_filled <= r_in.fill_mode;
                r_paint  <= r_in.paint;
            end else if (r_busy) begin
                if (at_last) begin
                    r_dec    <= n_dec;
                    r_step_x <= nx;
                    r_step_y <= ny;
                    r_sub    <= '0;
                    if (walk_end) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_sub <= r_sub + 3'd1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= (r_in.kind == KIND_STEP);
        end else if (o_span.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && (r_in.kind == KIND_STEP)) begin
            r_out <= n_out;
        end
    end

    assign o_span.valid      = r_out_valid;
    assign o_span.visible    = r_out.visible;
    assign o_span.span_start = r_out.span_start;
    assign o_span.span_end   = r_out.span_end;
    assign o_span.row        = r_out.row;
    assign o_span.span_paint = r_out.span_paint;
    assign o_span.done_res   = r_out.done_res;

endmodule

`default_nettype wire

/* src/mcsr_checker.sv */
// port checks of the circle span rasteriser and their bind
`timescale 1ns / 1ps
`default_nettype none

module mcsr_checker import mcsr_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic               i_visible,
    input wire logic [COL_W-1:0]   i_span_start,
    input wire logic [COL_W-1:0]   i_span_end,
    input wire logic [ROW_W-1:0]   i_row,
    input wire logic [PAINT_W-1:0] i_span_paint
);

    // a stalled span word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_span_start)
            && $stable(i_span_end) && $stable(i_row) && $stable(i_visible))
        else $error("span word changed while stalled");

    // an invisible span carries no geometry or colour
    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_visible |-> i_span_start == '0 && i_span_end == '0
            && i_row == '0 && i_span_paint == '0)
        else $error("invisible span with non-zero fields");

    // a visible span is never empty
    a_non_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_visible |-> i_span_start < i_span_end)
        else $error("visible span is empty");

    // no word straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("span word right after reset");

endmodule

bind midpoint_circle_span_rasterizer mcsr_checker u_mcsr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_span.valid),
    .i_out_ready  (o_span.ready),
    .i_visible    (o_span.visible),
    .i_span_start (o_span.span_start),
    .i_span_end   (o_span.span_end),
    .i_row        (o_span.row),
    .i_span_paint (o_span.span_paint)
);

`default_nettype wire

/* test/testbench.sv */
// self-checking testbench of the midpoint circle span rasteriser with a span predictor
`timescale 1ns / 1ps

module testbench;
    import mcsr_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    mcsr_in_if  item_ch ();
    mcsr_out_if span_ch ();

    midpoint_circle_span_rasterizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_span     (span_ch)
    );

    t_in_word   pending_words[$];
    t_span_word span_expected[$];
    t_in_word   word_on_bus;
    t_span_word span_got;
    t_span_word span_want;
    int         words_queued;
    int         fail_count;
    logic       calm;

    // scissor copies
    logic [COL_W-1:0] clip_left;
    logic [ROW_W-1:0] clip_top;
    logic [COL_W-1:0] clip_right;
    logic [ROW_W-1:0] clip_bottom;

    // circle walk copy
    logic                      walk_busy;
    logic signed [CTR_W-1:0]   walk_org_x;
    logic signed [CTR_W-1:0]   walk_org_y;
    t_step                     walk_x;
    t_step                     walk_y;
    t_dec                      walk_dec;
    logic        [SUB_W-1:0]   walk_sub;
    logic                      walk_fill;
    logic        [PAINT_W-1:0] walk_paint;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL midpoint_circle_span_rasterizer");
        $finish;
    end

    function automatic t_span_word clip_pixel(input int px, input int py, input logic fin);
        t_span_word s;
        s = '0;
        s.done_res = fin;
        if (px >= int'(clip_left) && px < int'(clip_right) &&
            py >= int'(clip_top) && py < int'(clip_bottom)) begin
            s.visible    = 1'b1;
            s.span_start = COL_W'(px);
            s.span_end   = COL_W'(px + 1);
            s.row        = ROW_W'(py);
            s.span_paint = walk_paint;
        end
        return s;
    endfunction

    function automatic t_span_word clip_hline(input int a, input int py, input int b,
                                              input logic fin);
        t_span_word s;
        int         l;
        int         r;
        int         t;
        s = '0;
        s.done_res = fin;
        l = int'(clip_left);
        r = int'(clip_right);
        if (py < int'(clip_top) || py >= int'(clip_bottom) ||
            (a < l && b < l) || (a >= r && b >= r)) begin
            return s;
        end
        if (a > b) begin
            t = a; a = b; b = t;
        end
        if (a < l) a = l;
        if (b > r) b = r;
        if (a > b) begin
            t = a; a = b; b = t;
        end
        if (a == b) return s;
        s.visible    = 1'b1;
        s.span_start = COL_W'(a);
        s.span_end   = COL_W'(b);
        s.row        = ROW_W'(py);
        s.span_paint = walk_paint;
        return s;
    endfunction

    task automatic advance_circle(input t_in_word w);
        t_span_word       s;
        int               cx;
        int               cy;
        int               x;
        int               y;
        int               nx;
        int               ny;
        logic [SUB_W-1:0] last;
        logic             fin;
        if (w.kind == KIND_START) begin
            walk_org_x = w.center_x;
            walk_org_y = w.center_y;
            walk_x     = '0;
            walk_y     = t_step'(w.radius);
            walk_dec   = t_dec'(3 - 2 * int'(w.radius));
            walk_sub   = '0;
            walk_fill  = w.fill_mode;
            walk_paint = w.paint;
            walk_busy  = 1'b1;
            return;
        end
        if (!walk_busy) begin
            s = '0;
            s.done_res = 1'b1;
            span_expected.push_back(s);
            return;
        end
        cx   = int'(walk_org_x);
        cy   = int'(walk_org_y);
        x    = int'(walk_x);
        y    = int'(walk_y);
        last = walk_fill ? SUB_LAST_FILL : SUB_LAST_OUTLINE;
        fin  = 1'b0;
        if (walk_sub >= last) begin
            nx = x + 1;
            ny = y;
            if (walk_dec < 0) begin
                walk_dec = t_dec'(int'(walk_dec) + 4 * x + 6);
            end else begin
                walk_dec = t_dec'(int'(walk_dec) + 4 * (x - y) + 10);
                ny = y - 1;
            end
            if (nx > ny) begin
                fin = 1'b1;
                walk_busy = 1'b0;
            end
            walk_x = t_step'(nx);
            walk_y = t_step'(ny);
        end
        if (walk_fill) begin
            case (walk_sub[1:0])
                2'd0:    s = clip_hline(cx - x, cy - y, cx + x + 1, fin);
                2'd1:    s = clip_hline(cx - x, cy + y, cx + x + 1, fin);
                2'd2:    s = clip_hline(cx - y, cy - x, cx + y + 1, fin);
                default: s = clip_hline(cx - y, cy + x, cx + y + 1, fin);
            endcase
        end else begin
            case (walk_sub)
                3'd0:    s = clip_pixel(cx + x, cy + y, fin);
                3'd1:    s = clip_pixel(cx - x, cy + y, fin);
                3'd2:    s = clip_pixel(cx + x, cy - y, fin);
                3'd3:    s = clip_pixel(cx - x, cy - y, fin);
                3'd4:    s = clip_pixel(cx + y, cy + x, fin);
                3'd5:    s = clip_pixel(cx - y, cy + x, fin);
                3'd6:    s = clip_pixel(cx + y, cy - x, fin);
                default: s = clip_pixel(cx - y, cy - x, fin);
            endcase
        end
        walk_sub = (walk_sub >= last) ? '0 : walk_sub + 1'b1;
        span_expected.push_back(s);
    endtask

    // input word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                advance_circle(word_on_bus);
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                    word_on_bus        = pending_words.pop_front();
                    item_ch.kind      <= word_on_bus.kind;
                    item_ch.center_x  <= word_on_bus.center_x;
                    item_ch.center_y  <= word_on_bus.center_y;
                    item_ch.radius    <= word_on_bus.radius;
                    item_ch.fill_mode <= word_on_bus.fill_mode;
                    item_ch.paint     <= word_on_bus.paint;
                    item_ch.valid     <= 1'b1;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // span monitor
    always @(posedge i_clk) begin
        if (i_rst_n && span_ch.valid && span_ch.ready) begin
            span_got.visible    = span_ch.visible;
            span_got.span_start = span_ch.span_start;
            span_got.span_end   = span_ch.span_end;
            span_got.row        = span_ch.row;
            span_got.span_paint = span_ch.span_paint;
            span_got.done_res   = span_ch.done_res;
            if (span_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected span: vis %0d [%0d,%0d) row %0d paint %h done %0d",
                             span_got.visible, span_got.span_start, span_got.span_end,
                             span_got.row, span_got.span_paint, span_got.done_res);
                end
            end else begin
                span_want = span_expected.pop_front();
                if (span_got !== span_want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"span mismatch: expected vis %0d [%0d,%0d) row %0d ",
                                  "paint %h done %0d, got vis %0d [%0d,%0d) row %0d ",
                                  "paint %h done %0d"},
                                 span_want.visible, span_want.span_start, span_want.span_end,
                                 span_want.row, span_want.span_paint, span_want.done_res,
                                 span_got.visible, span_got.span_start, span_got.span_end,
                                 span_got.row, span_got.span_paint, span_got.done_res);
                    end
                end
            end
        end
        span_ch.ready <= calm || ($urandom_range(99) >= 33);
    end

    task automatic queue_word(input logic k, input int ccx, input int ccy, input int rad,
                              input logic f, input int p);
        t_in_word w;
        w.kind      = k;
        w.center_x  = CTR_W'(ccx);
        w.center_y  = CTR_W'(ccy);
        w.radius    = RAD_W'(rad);
        w.fill_mode = f;
        w.paint     = PAINT_W'(p);
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_steps(input int n);
        repeat (n) begin
            queue_word(KIND_STEP, $urandom, $urandom, $urandom, 1'($urandom), $urandom);
        end
    endtask

    task automatic queue_random_circle();
        int   cx;
        int   cy;
        int   r;
        int   x;
        int   y;
        int   d;
        int   nx;
        int   ny;
        int   iters;
        int   steps;
        logic f;
        if ($urandom_range(99) < 8) begin
            queue_word(1'($urandom_range(1)), $urandom, $urandom, $urandom, 1'($urandom),
                       $urandom);
            return;
        end
        case ($urandom_range(19))
            0: begin
                cx = $urandom_range(4095) - 2048;
                cy = $urandom_range(4095) - 2048;
                r  = $urandom_range(1023);
            end
            1: begin
                cx = $urandom_range(380) - 30;
                cy = $urandom_range(300) - 30;
                r  = $urandom_range(1023);
            end
            default: begin
                cx = $urandom_range(380) - 30;
                cy = $urandom_range(300) - 30;
                r  = $urandom_range(14);
            end
        endcase
        f = 1'($urandom_range(1));
        queue_word(KIND_START, cx, cy, r, f, $urandom);
        // length of the walk for this radius
        x = 0;
        y = r;
        d = 3 - 2 * r;
        iters = 0;
        do begin
            iters++;
            nx = x + 1;
            ny = y;
            if (d < 0) begin
                d = d + 4 * x + 6;
            end else begin
                d = d + 4 * (x - y) + 10;
                ny = y - 1;
            end
            x = nx;
            y = ny;
        end while (x <= y);
        steps = iters * (f ? 4 : 8);
        if (r > 40 || $urandom_range(9) == 0) begin
            steps = $urandom_range(1, (steps < 40) ? steps : 40);
        end else if ($urandom_range(3) == 0) begin
            steps = steps + $urandom_range(1, 2);
        end
        queue_steps(steps);
    endtask

    task automatic queue_random_words(input int n);
        int target;
        target = words_queued + n;
        while (words_queued < target) queue_random_circle();
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || item_ch.valid || span_expected.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_scissors(input int l, input int t, input int r, input int b);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_LEFT;
        i_cfg_data <= CFG_W'(l);
        @(posedge i_clk);
        i_cfg_idx  <= REG_TOP;
        i_cfg_data <= CFG_W'(t);
        @(posedge i_clk);
        i_cfg_idx  <= REG_RIGHT;
        i_cfg_data <= CFG_W'(r);
        @(posedge i_clk);
        i_cfg_idx  <= REG_BOTTOM;
        i_cfg_data <= CFG_W'(b);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        clip_left   = COL_W'(l);
        clip_top    = ROW_W'(t);
        clip_right  = COL_W'(r);
        clip_bottom = ROW_W'(b);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_LEFT;
        i_cfg_data        = '0;
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_START;
        item_ch.center_x  = '0;
        item_ch.center_y  = '0;
        item_ch.radius    = '0;
        item_ch.fill_mode = 1'b0;
        item_ch.paint     = '0;
        span_ch.ready     = 1'b0;
        calm              = 1'b0;
        words_queued      = 0;
        fail_count        = 0;
        word_on_bus       = '0;
        clip_left         = '0;
        clip_top          = '0;
        clip_right        = RIGHT_RST;
        clip_bottom       = BOTTOM_RST;
        walk_busy         = 1'b0;
        walk_org_x        = '0;
        walk_org_y        = '0;
        walk_x            = '0;
        walk_y            = '0;
        walk_dec          = '0;
        walk_sub          = '0;
        walk_fill         = 1'b0;
        walk_paint        = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step while idle, single point, corner fill, extreme abandoned circles, radius-one fill run past its end
        queue_word(KIND_STEP, 0, 0, 0, 1'b0, 0);
        queue_word(KIND_START, 5, 5, 0, 1'b0, 'h1234);
        queue_steps(8);
        queue_word(KIND_START, 319, 239, 0, 1'b1, 'hFFFF);
        queue_steps(4);
        queue_word(KIND_START, -2048, 2047, 1023, 1'b1, 'hFFFF);
        queue_steps(2);
        queue_word(KIND_START, 2047, -2048, 1023, 1'b0, 'h0000);
        queue_steps(1);
        queue_word(KIND_START, 0, 0, 1, 1'b1, 'hA5A5);
        queue_steps(5);
        queue_random_words(260);
        drain();

        load_scissors(100, 80, 140, 120);
        queue_random_words(260);
        drain();

        // inverted window
        load_scissors(300, 200, 10, 20);
        queue_random_words(260);
        drain();

        load_scissors(0, 0, 0, 0);
        queue_random_words(260);
        drain();

        load_scissors(320, 240, 320, 240);
        queue_random_words(260);
        drain();

        calm = 1'b1;
        load_scissors($urandom_range(320), $urandom_range(240),
                      $urandom_range(320), $urandom_range(240));
        queue_random_words(260);
        drain();
        calm = 1'b0;

        load_scissors(0, 0, 320, 240);
        queue_random_words(260);
        drain();

        if (fail_count == 0) begin
            $display("PASS midpoint_circle_span_rasterizer");
        end else begin
            $display("FAIL midpoint_circle_span_rasterizer");
        end
        $finish;
    end

endmodule

/* files.f */
src/mcsr_pkg.sv
src/mcsr_in_if.sv
src/mcsr_out_if.sv
src/midpoint_circle_span_rasterizer.sv
src/mcsr_checker.sv
test/testbench.sv
